FILE: src/kh_pkg.sv
package kh_pkg;

    localparam int SIZE_BITS = 24;
    localparam int CODE_W    = 31;
    localparam int CNT_W     = $clog2(CODE_W);

    localparam logic [31:0] RS_STEP   = 32'd378551;
    localparam logic [31:0] RS_START  = 32'd63689;
    localparam logic [31:0] BKDR_SEED = 32'd131;
    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(CODE_W - 1);
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(3);

    typedef struct packed {
        logic [7:0] key_byte;
        logic       last_byte;
    } kh_in_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0] bucket_index;
        logic [CODE_W-1:0]    bkdr_code;
    } kh_out_t;

    typedef struct packed {
        logic [CODE_W-1:0] rs31;
        logic [CODE_W-1:0] code;
    } kh_job_t;

    typedef struct packed {
        logic valid;
        logic full;
    } kh_qstat_t;

endpackage

FILE: src/kh_front.sv
module kh_front
    import kh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    key_valid,
    output logic    key_stall,
    input  kh_in_t  key,
    input  logic    q_full,
    output logic    push,
    output kh_job_t push_job
);

    logic [31:0] rs_accum_reg, rs_accum_next;
    logic [31:0] rs_mult_reg, rs_mult_next;
    logic [31:0] bkdr_reg, bkdr_next;
    logic [31:0] add;
    logic        accept;

    assign key_stall = q_full;
    assign accept    = key_valid && !q_full;
    assign push      = accept && key.last_byte;
    assign add       = {{24{key.key_byte[7]}}, key.key_byte};

    always_comb
    begin
        rs_accum_next = rs_accum_reg * rs_mult_reg + add;
        rs_mult_next  = rs_mult_reg * RS_STEP;
        bkdr_next     = bkdr_reg * BKDR_SEED + add;
    end

    assign push_job.rs31 = rs_accum_next[CODE_W-1:0];
    assign push_job.code = bkdr_next[CODE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_accum_reg <= '0;
            rs_mult_reg  <= RS_START;
            bkdr_reg     <= '0;
        end
        else if (accept)
        begin
            if (key.last_byte)
            begin
                rs_accum_reg <= '0;
                rs_mult_reg  <= RS_START;
                bkdr_reg     <= '0;
            end
            else
            begin
                rs_accum_reg <= rs_accum_next;
                rs_mult_reg  <= rs_mult_next;
                bkdr_reg     <= bkdr_next;
            end
        end
    end

endmodule

FILE: src/kh_queue.sv
module kh_queue
    import kh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  kh_job_t   push_job,
    input  logic      pop,
    output kh_job_t   head,
    output kh_qstat_t stat
);

    kh_job_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.valid = count_reg != 2'd0;
    assign stat.full  = count_reg == 2'd2;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: src/kh_back.sv
module kh_back
    import kh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SIZE_BITS-1:0] table_size,
    input  kh_qstat_t            stat,
    input  kh_job_t              head,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output kh_out_t              result
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } kh_state_t;

    kh_state_t            state_reg, state_next;
    logic [CODE_W-1:0]    dividend_reg;
    logic [CODE_W-1:0]    code_reg;
    logic [SIZE_BITS-1:0] rem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 valid_reg;
    kh_out_t              result_reg;
    logic [SIZE_BITS:0]   trial;
    logic [SIZE_BITS:0]   diff;
    logic                 out_free;

    assign result_valid = valid_reg;
    assign result       = result_reg;
    assign out_free     = !valid_reg || !result_stall;
    assign pop          = (state_reg == ST_IDLE) && stat.valid;

    assign trial = {rem_reg, dividend_reg[CODE_W-1]};
    assign diff  = trial - {1'b0, table_size};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (stat.valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == STEP_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            dividend_reg <= head.rs31;
            code_reg     <= head.code;
            rem_reg      <= '0;
            cnt_reg      <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            dividend_reg <= {dividend_reg[CODE_W-2:0], 1'b0};
            cnt_reg      <= cnt_reg + CNT_W'(1);
            if (trial >= {1'b0, table_size})
            begin
                rem_reg <= diff[SIZE_BITS-1:0];
            end
            else
            begin
                rem_reg <= trial[SIZE_BITS-1:0];
            end
        end
        if (state_reg == ST_DONE && out_free)
        begin
            result_reg.bucket_index <= (table_size == '0) ? '0 : rem_reg;
            result_reg.bkdr_code    <= code_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
            begin
                valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: src/key_hash_bucket_and_code_top.sv
// a key byte is taken every cycle unless key_stall is high; the last byte's job passes the
// request queue, the bit-serial bucket divider (one key at a time) and the result register
// a two-entry request queue lets the byte front run ahead of the divider by two keys
// reset: rst_n is asynchronous, active low; hash state returns to its start values,
// table_size returns to 3, queue and result register are emptied
module key_hash_bucket_and_code_top
    import kh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [SIZE_BITS-1:0] cfg_wdata,
    input  logic                 key_valid,
    output logic                 key_stall,
    input  kh_in_t               key,
    output logic                 result_valid,
    input  logic                 result_stall,
    output kh_out_t              result
);

    logic [SIZE_BITS-1:0] size_reg;
    logic                 push;
    logic                 pop;
    kh_job_t              push_job;
    kh_job_t              head;
    kh_qstat_t            stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    kh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .key       (key),
        .q_full    (stat.full),
        .push      (push),
        .push_job  (push_job)
    );

    kh_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    kh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .table_size   (size_reg),
        .stat         (stat),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> stat.valid)
        else $error("request popped from empty queue");

    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && size_reg != '0) |-> (result.bucket_index < size_reg))
        else $error("bucket index out of range");

    a_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && size_reg == '0) |-> (result.bucket_index == '0))
        else $error("nonzero bucket with zero table size");

endmodule
